### rtl/core/ssd_pkg.sv
// Shared types and constants for the symmetry shortest-distance block.
// Used by ssd_front, ssd_back and symmetry_shortest_distance. No dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

    localparam int MAX_ATOMS    = 1024;
    localparam int ATOM_AW      = 10;
    localparam int MAX_SYMMETRY = 64;
    localparam int SYM_IW       = 6;
    localparam int SYM_DEPTH    = MAX_SYMMETRY * 3;
    localparam int SYM_AW       = 8;

    localparam logic [1:0]  OP_LOAD_SYM  = 2'd0;
    localparam logic [1:0]  OP_LOAD_ATOM = 2'd1;
    localparam logic [1:0]  OP_QUERY     = 2'd2;
    localparam logic [1:0]  OP_RESERVED  = 2'd3;
    localparam logic [1:0]  AXIS_LAST    = 2'd2;
    localparam logic [1:0]  AXIS_RESERVED = 2'd3;

    localparam logic [2:0]  CFG_GXY   = 3'd0;
    localparam logic [2:0]  CFG_GXZ   = 3'd1;
    localparam logic [2:0]  CFG_GYZ   = 3'd2;
    localparam logic [2:0]  CFG_ASQ   = 3'd3;
    localparam logic [2:0]  CFG_BSQ   = 3'd4;
    localparam logic [2:0]  CFG_CSQ   = 3'd5;
    localparam logic [2:0]  CFG_COUNT = 3'd6;

    localparam logic [47:0] HALF48     = 48'h8000_0000_0000;
    localparam logic [59:0] LIMIT_SQ   = 60'd1 << 44;
    localparam logic [18:0] PENALTY    = 19'd7;
    localparam logic [18:0] MIN_DIST   = 19'd655;
    localparam logic [23:0] RECIP_TEN  = 24'd13421773;   // ceil(2^27 / 10)
    localparam logic [4:0]  COL_LAST   = 5'd5;
    localparam logic [4:0]  MET_LAST   = 5'd7;
    localparam logic [4:0]  SQRT_LAST  = 5'd22;

    typedef struct packed {
        logic        [1:0]  op;
        logic        [9:0]  first_index;
        logic        [9:0]  second_index;
        logic        [1:0]  axis;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic signed [31:0] value_shift;
        logic        [17:0] radius;
        logic               hydrogen;
        logic signed [7:0]  part;
    } t_in_item;

    typedef struct packed {
        logic        [9:0]  atom_i;
        logic        [9:0]  atom_j;
        logic        [5:0]  best_symmetry;
        logic        [18:0] distance;
        logic        [19:0] cutoff;
        logic               covalent;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] cross_ab_gamma;
        logic signed [31:0] cross_ac_beta;
        logic signed [31:0] cross_bc_alpha;
        logic        [30:0] a_squared;
        logic        [30:0] b_squared;
        logic        [30:0] c_squared;
        logic        [6:0]  symmetry_count;
    } t_cfg;

    typedef enum logic [1:0] {
        K_LOAD_SYM,
        K_LOAD_ATOM,
        K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_cmd;

    typedef struct packed {
        logic [17:0]       radius;
        logic              hydrogen;
        logic signed [7:0] part;
    } t_attr;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_I,
        ST_RD_J,
        ST_GET_J,
        ST_COL,
        ST_METRIC,
        ST_CHK,
        ST_SQRT,
        ST_PICK,
        ST_NEXT,
        ST_CUT0,
        ST_CUT1,
        ST_EMIT
    } t_state;

endpackage

### rtl/core/ssd_front.sv
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ssd_pkg::t_in_item i_item,
    output logic             o_cmd_valid,
    output ssd_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_pop
);

    ssd_pkg::t_cmd r_q [2];
    logic [1:0]    r_count;
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic          accept;
    logic          keep;
    ssd_pkg::t_cmd cmd_in;

    assign busy   = (r_count == 2'd2);
    assign accept = start && !busy;

    // bad symmetry index, axis 3 and op 3 are dropped here
    always_comb begin
        cmd_in.item = i_item;
        cmd_in.kind = ssd_pkg::K_QUERY;
        keep        = 1'b0;
        case (i_item.op)
            ssd_pkg::OP_LOAD_SYM: begin
                cmd_in.kind = ssd_pkg::K_LOAD_SYM;
                keep = (i_item.first_index[9:ssd_pkg::SYM_IW] == '0) &&
                       (i_item.axis <= ssd_pkg::AXIS_LAST);
            end
            ssd_pkg::OP_LOAD_ATOM: begin
                cmd_in.kind = ssd_pkg::K_LOAD_ATOM;
                keep = 1'b1;
            end
            ssd_pkg::OP_QUERY: begin
                cmd_in.kind = ssd_pkg::K_QUERY;
                keep = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (accept && keep) begin
                r_q[r_wr_ptr] <= cmd_in;
                r_wr_ptr      <= ~r_wr_ptr;
            end
            if (i_cmd_pop && o_cmd_valid) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, accept && keep}
                               - {1'b0, i_cmd_pop && o_cmd_valid};
        end
    end

endmodule

### rtl/core/ssd_back.sv
// Back end: symmetry and atom tables, per-operation distance sequencer,
// square root, cutoff and result register. Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssd_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  ssd_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    output ssd_pkg::t_out_item o_result
);

    ssd_pkg::t_state r_state, n_state;

    // tables
    logic [31:0]   mem_m0 [ssd_pkg::SYM_DEPTH];
    logic [31:0]   mem_m1 [ssd_pkg::SYM_DEPTH];
    logic [31:0]   mem_m2 [ssd_pkg::SYM_DEPTH];
    logic [31:0]   mem_sh [ssd_pkg::SYM_DEPTH];
    logic [31:0]   mem_px [ssd_pkg::MAX_ATOMS];
    logic [31:0]   mem_py [ssd_pkg::MAX_ATOMS];
    logic [31:0]   mem_pz [ssd_pkg::MAX_ATOMS];
    ssd_pkg::t_attr mem_at [ssd_pkg::MAX_ATOMS];

    logic [31:0]   r_m0, r_m1, r_m2, r_sh;
    logic [31:0]   r_ax, r_ay, r_az;
    ssd_pkg::t_attr r_at;

    logic [4:0]    r_step;
    logic [1:0]    r_col;
    logic [6:0]    r_n;
    logic [6:0]    r_nops;
    logic [9:0]    r_fi, r_se;
    logic signed [31:0] r_pi [3];
    logic signed [31:0] r_pj [3];
    ssd_pkg::t_attr r_att_i, r_att_j;
    logic [47:0]   r_prod, r_acc;
    logic signed [23:0] r_dp [3];
    logic signed [47:0] r_p1;
    logic signed [57:0] r_p2;
    logic signed [59:0] r_dk2;
    logic [45:0]   r_rad;
    logic [22:0]   r_root;
    logic [24:0]   r_rem;
    logic          r_found;
    logic [18:0]   r_best_d;
    logic [5:0]    r_best_n;
    logic [22:0]   r_sum12;
    logic          r_cut_en;
    logic [46:0]   r_qprod;
    ssd_pkg::t_out_item r_out;
    logic          r_out_valid;

    logic          pop;
    logic          is_query;
    logic [6:0]    nops;
    logic [5:0]    wr_sym;
    logic [7:0]    sym_wa, sym_ra;
    logic [9:0]    atom_ra;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] pos_prod;
    logic [47:0]   sh_term, pj_term;
    logic signed [23:0] met_a, met_b;
    logic signed [33:0] met_r;
    logic signed [47:0] met_p1;
    logic signed [57:0] met_p2;
    logic          skip;
    logic [25:0]   rem_n, trial;
    logic          ge;
    logic [18:0]   dk;
    logic          better;
    logic          more_ops;
    logic [18:0]   rsum;
    logic          no_h;
    logic [19:0]   cut;

    // ---------------- control ----------------
    assign is_query = (i_cmd.kind == ssd_pkg::K_QUERY);
    assign nops = (i_cfg.symmetry_count > 7'(ssd_pkg::MAX_SYMMETRY)) ?
                  7'(ssd_pkg::MAX_SYMMETRY) : i_cfg.symmetry_count;
    assign skip = r_dk2[59] || (r_dk2 > $signed(ssd_pkg::LIMIT_SQ));
    assign more_ops = ({1'b0, r_n} + 8'd1) < {1'b0, r_nops};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssd_pkg::ST_IDLE:
                if (i_cmd_valid && is_query && (nops != 7'd0)) n_state = ssd_pkg::ST_RD_I;
            ssd_pkg::ST_RD_I:  n_state = ssd_pkg::ST_RD_J;
            ssd_pkg::ST_RD_J:  n_state = ssd_pkg::ST_GET_J;
            ssd_pkg::ST_GET_J: n_state = ssd_pkg::ST_COL;
            ssd_pkg::ST_COL:
                if (r_step == ssd_pkg::COL_LAST && r_col == ssd_pkg::AXIS_LAST)
                    n_state = ssd_pkg::ST_METRIC;
            ssd_pkg::ST_METRIC:
                if (r_step == ssd_pkg::MET_LAST) n_state = ssd_pkg::ST_CHK;
            ssd_pkg::ST_CHK:
                n_state = skip ? ssd_pkg::ST_NEXT : ssd_pkg::ST_SQRT;
            ssd_pkg::ST_SQRT:
                if (r_step == ssd_pkg::SQRT_LAST) n_state = ssd_pkg::ST_PICK;
            ssd_pkg::ST_PICK:  n_state = ssd_pkg::ST_NEXT;
            ssd_pkg::ST_NEXT: begin
                if (more_ops)     n_state = ssd_pkg::ST_COL;
                else if (r_found) n_state = ssd_pkg::ST_CUT0;
                else              n_state = ssd_pkg::ST_IDLE;
            end
            ssd_pkg::ST_CUT0:  n_state = ssd_pkg::ST_CUT1;
            ssd_pkg::ST_CUT1:  n_state = ssd_pkg::ST_EMIT;
            ssd_pkg::ST_EMIT:  n_state = ssd_pkg::ST_IDLE;
            default:           n_state = ssd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pop = (r_state == ssd_pkg::ST_IDLE) && i_cmd_valid;
    end

    assign o_cmd_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ssd_pkg::ST_EMIT);
        end
    end

    // ---------------- tables ----------------
    assign wr_sym  = i_cmd.item.first_index[ssd_pkg::SYM_IW-1:0];
    assign sym_wa  = ({2'b0, wr_sym} << 1) + {2'b0, wr_sym} + {6'b0, i_cmd.item.axis};
    assign sym_ra  = ({2'b0, r_n[5:0]} << 1) + {2'b0, r_n[5:0]} + {6'b0, r_col};
    assign atom_ra = (r_state == ssd_pkg::ST_RD_I) ? r_fi : r_se;

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == ssd_pkg::K_LOAD_SYM) begin
            mem_m0[sym_wa] <= i_cmd.item.value_x;
            mem_m1[sym_wa] <= i_cmd.item.value_y;
            mem_m2[sym_wa] <= i_cmd.item.value_z;
            mem_sh[sym_wa] <= i_cmd.item.value_shift;
        end
        r_m0 <= mem_m0[sym_ra];
        r_m1 <= mem_m1[sym_ra];
        r_m2 <= mem_m2[sym_ra];
        r_sh <= mem_sh[sym_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.kind == ssd_pkg::K_LOAD_ATOM) begin
            mem_px[i_cmd.item.first_index] <= i_cmd.item.value_x;
            mem_py[i_cmd.item.first_index] <= i_cmd.item.value_y;
            mem_pz[i_cmd.item.first_index] <= i_cmd.item.value_z;
            mem_at[i_cmd.item.first_index] <= '{radius:   i_cmd.item.radius,
                                                hydrogen: i_cmd.item.hydrogen,
                                                part:     i_cmd.item.part};
        end
        r_ax <= mem_px[atom_ra];
        r_ay <= mem_py[atom_ra];
        r_az <= mem_pz[atom_ra];
        r_at <= mem_at[atom_ra];
    end

    // ---------------- datapath ----------------
    always_comb begin
        case (r_step)
            5'd1:    begin mul_a = r_pi[0]; mul_b = r_m0; end
            5'd2:    begin mul_a = r_pi[1]; mul_b = r_m1; end
            default: begin mul_a = r_pi[2]; mul_b = r_m2; end
        endcase
        pos_prod = mul_a * mul_b;
        sh_term  = {r_sh[23:0], 24'b0};
        pj_term  = {r_pj[r_col][23:0], 24'b0};
    end

    always_comb begin
        case (r_step)
            5'd0:    begin met_a = r_dp[0]; met_b = r_dp[0]; end
            5'd1:    begin met_a = r_dp[1]; met_b = r_dp[1]; end
            5'd2:    begin met_a = r_dp[2]; met_b = r_dp[2]; end
            5'd3:    begin met_a = r_dp[0]; met_b = r_dp[1]; end
            5'd4:    begin met_a = r_dp[0]; met_b = r_dp[2]; end
            default: begin met_a = r_dp[1]; met_b = r_dp[2]; end
        endcase
        // metric entry for the product held in r_p1; cross terms doubled
        case (r_step)
            5'd1:    met_r = $signed({3'b0, i_cfg.a_squared});
            5'd2:    met_r = $signed({3'b0, i_cfg.b_squared});
            5'd3:    met_r = $signed({3'b0, i_cfg.c_squared});
            5'd4:    met_r = {i_cfg.cross_ab_gamma[31], i_cfg.cross_ab_gamma, 1'b0};
            5'd5:    met_r = {i_cfg.cross_ac_beta[31], i_cfg.cross_ac_beta, 1'b0};
            default: met_r = {i_cfg.cross_bc_alpha[31], i_cfg.cross_bc_alpha, 1'b0};
        endcase
        met_p1 = met_a * met_b;
        met_p2 = $signed(r_p1[47:24]) * met_r;   // floor of the Q.48 product to Q.24
    end

    always_comb begin
        rem_n  = {r_rem[23:0], r_rad[45:44]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = (rem_n >= trial);
        dk     = 19'((r_root + 23'd8) >> 4) +
                 ((r_n != 7'd0) ? ssd_pkg::PENALTY : 19'd0);
        better = (dk > ssd_pkg::MIN_DIST) && (!r_found || r_best_d >= dk);
        rsum   = {1'b0, r_att_i.radius} + {1'b0, r_att_j.radius};
        no_h   = !r_att_i.hydrogen && !r_att_j.hydrogen;
        cut    = r_cut_en ? r_qprod[46:27] : 20'd0;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ssd_pkg::ST_IDLE: begin
                if (pop && is_query) begin
                    r_fi    <= i_cmd.item.first_index;
                    r_se    <= i_cmd.item.second_index;
                    r_nops  <= nops;
                    r_n     <= 7'd0;
                    r_found <= 1'b0;
                end
            end
            ssd_pkg::ST_RD_J: begin
                r_pi[0] <= r_ax;
                r_pi[1] <= r_ay;
                r_pi[2] <= r_az;
                r_att_i <= r_at;
            end
            ssd_pkg::ST_GET_J: begin
                r_pj[0] <= r_ax;
                r_pj[1] <= r_ay;
                r_pj[2] <= r_az;
                r_att_j <= r_at;
                r_col   <= 2'd0;
                r_step  <= 5'd0;
            end
            ssd_pkg::ST_COL: begin
                // step 0 addresses the tables, 1..3 multiply, 2..4 accumulate
                if (r_step >= 5'd1 && r_step <= 5'd3) r_prod <= pos_prod[47:0];
                if (r_step == 5'd2) r_acc <= r_prod;
                if (r_step == 5'd3) r_acc <= r_acc + r_prod;
                if (r_step == 5'd4) r_acc <= r_acc + r_prod + sh_term - pj_term
                                             - ssd_pkg::HALF48;
                if (r_step == ssd_pkg::COL_LAST) begin
                    r_dp[r_col] <= $signed({~r_acc[47], r_acc[46:24]});
                    r_step      <= 5'd0;
                    if (r_col != ssd_pkg::AXIS_LAST) r_col <= r_col + 2'd1;
                end else begin
                    r_step <= r_step + 5'd1;
                end
            end
            ssd_pkg::ST_METRIC: begin
                if (r_step <= 5'd5) r_p1 <= met_p1;
                if (r_step >= 5'd1 && r_step <= 5'd6) r_p2 <= met_p2;
                if (r_step == 5'd0) r_dk2 <= '0;
                else if (r_step >= 5'd2) r_dk2 <= r_dk2 + {{2{r_p2[57]}}, r_p2};
                r_step <= (r_step == ssd_pkg::MET_LAST) ? 5'd0 : r_step + 5'd1;
            end
            ssd_pkg::ST_CHK: begin
                r_rad  <= r_dk2[45:0];
                r_root <= '0;
                r_rem  <= '0;
                r_step <= 5'd0;
            end
            ssd_pkg::ST_SQRT: begin
                r_rem  <= ge ? 25'(rem_n - trial) : 25'(rem_n);
                r_root <= {r_root[21:0], ge};
                r_rad  <= {r_rad[43:0], 2'b00};
                r_step <= r_step + 5'd1;
            end
            ssd_pkg::ST_PICK: begin
                if (better) begin
                    r_found  <= 1'b1;
                    r_best_d <= dk;
                    r_best_n <= r_n[5:0];
                end
            end
            ssd_pkg::ST_NEXT: begin
                r_n    <= r_n + 7'd1;
                r_col  <= 2'd0;
                r_step <= 5'd0;
            end
            ssd_pkg::ST_CUT0: begin
                r_sum12  <= ({4'b0, rsum} << 3) + ({4'b0, rsum} << 2) + 23'd5;
                r_cut_en <= (no_h && (r_att_i.part == 8'sd0 || r_att_j.part == 8'sd0)) ||
                            (r_att_i.part == r_att_j.part);
            end
            ssd_pkg::ST_CUT1: begin
                r_qprod <= 47'(r_sum12 * ssd_pkg::RECIP_TEN);
            end
            ssd_pkg::ST_EMIT: begin
                r_out.atom_i        <= r_fi;
                r_out.atom_j        <= r_se;
                r_out.best_symmetry <= r_best_n;
                r_out.distance      <= r_best_d;
                r_out.cutoff        <= cut;
                r_out.covalent      <= ({1'b0, r_best_d} < cut);
            end
            default: ;
        endcase
    end

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held for two cycles");

    a_min_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.distance > ssd_pkg::MIN_DIST))
        else $error("reported distance not above the minimum");

    a_sqrt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssd_pkg::ST_SQRT) |-> (r_step <= ssd_pkg::SQRT_LAST))
        else $error("square root ran past its last digit");

    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssd_pkg::ST_EMIT) |-> r_found)
        else $error("emit without a valid copy");

endmodule

### rtl/core/symmetry_shortest_distance.sv
// Top level: cell metric and operation-count registers, front queue and back end.
// Depends on ssd_pkg, ssd_front, ssd_back.
// The back end takes an item only while idle; a load goes straight into its table and a
// query steps through N = operations in use (up to 64), raising its result strobe if a
// copy is found. Each copy runs matrix products, metric, check, square root, pick and
// step; a copy beyond the distance limit skips the root and pick. A two-item queue lets
// the sender run ahead; busy is high while it is full. The receiver cannot stall.
// Synchronous active-low reset clears queue and sequencer; cfg registers take defaults.
`timescale 1ns / 1ps

module symmetry_shortest_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ssd_pkg::t_in_item  i_item,
    output logic               o_valid,
    output ssd_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    ssd_pkg::t_cfg r_cfg;
    logic          cmd_valid;
    ssd_pkg::t_cmd cmd;
    logic          cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cross_ab_gamma <= '0;
            r_cfg.cross_ac_beta  <= '0;
            r_cfg.cross_bc_alpha <= '0;
            r_cfg.a_squared      <= 31'd65536;
            r_cfg.b_squared      <= 31'd65536;
            r_cfg.c_squared      <= 31'd65536;
            r_cfg.symmetry_count <= 7'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ssd_pkg::CFG_GXY:   r_cfg.cross_ab_gamma <= i_cfg_data;
                ssd_pkg::CFG_GXZ:   r_cfg.cross_ac_beta  <= i_cfg_data;
                ssd_pkg::CFG_GYZ:   r_cfg.cross_bc_alpha <= i_cfg_data;
                ssd_pkg::CFG_ASQ:   r_cfg.a_squared      <= i_cfg_data[30:0];
                ssd_pkg::CFG_BSQ:   r_cfg.b_squared      <= i_cfg_data[30:0];
                ssd_pkg::CFG_CSQ:   r_cfg.c_squared      <= i_cfg_data[30:0];
                ssd_pkg::CFG_COUNT: r_cfg.symmetry_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ssd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

### tb/testbench.sv
// Self-checking bench for symmetry_shortest_distance: loads, pair queries and metric phases.
// Carries its own predictor of the shortest-distance search; depends on ssd_pkg and symmetry_shortest_distance.
`timescale 1ns / 1ps

module testbench;

    // up to three full-length queries can still be in flight once the sender stops
    localparam int DRAIN_CYCLES = 3 * (8 + 52 * ssd_pkg::MAX_SYMMETRY) + 64;
    localparam int WATCHDOG     = 50000;
    localparam logic [63:0] ONE_Q24 = 64'd1 << 24;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    ssd_pkg::t_in_item  i_item;
    logic               o_valid;
    ssd_pkg::t_out_item o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    symmetry_shortest_distance uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of the block state
    logic signed [31:0] mdl_matrix [ssd_pkg::MAX_SYMMETRY * 9];
    logic signed [31:0] mdl_shift  [ssd_pkg::MAX_SYMMETRY * 3];
    logic signed [31:0] mdl_pos    [ssd_pkg::MAX_ATOMS * 3];
    logic [17:0]        mdl_radius [ssd_pkg::MAX_ATOMS];
    logic               mdl_hyd    [ssd_pkg::MAX_ATOMS];
    logic signed [7:0]  mdl_part   [ssd_pkg::MAX_ATOMS];
    ssd_pkg::t_cfg      mdl_cfg;

    ssd_pkg::t_in_item  pending_items [$];
    ssd_pkg::t_out_item expected_pairs [$];

    // generator-side bookkeeping so no query reads an unwritten atom
    bit atom_written [ssd_pkg::MAX_ATOMS];
    int atom_list [$];

    int  mismatches;
    bit  failed;
    bit  sent;
    bit  no_gaps;
    int  quiet_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // nearest symmetry copy of atom i around atom j; returns 1 when a pair result is due
    function automatic bit nearest_copy(input ssd_pkg::t_in_item it,
                                        output ssd_pkg::t_out_item res);
        int              nops;
        int              fi;
        int              se;
        bit              found;
        longint          best_d;
        int              best_n;
        longint          pi [3];
        longint          dp [3];
        longint          dk2;
        longint          dk;
        logic [63:0]     acc;
        longint          gxy;
        longint          gxz;
        longint          gyz;
        longint          cut;
        bit              no_h;
        fi = it.first_index;
        se = it.second_index;
        found = 0;
        best_d = 0;
        best_n = 0;
        nops = mdl_cfg.symmetry_count;
        if (nops > ssd_pkg::MAX_SYMMETRY) nops = ssd_pkg::MAX_SYMMETRY;
        gxy = longint'(mdl_cfg.cross_ab_gamma);
        gxz = longint'(mdl_cfg.cross_ac_beta);
        gyz = longint'(mdl_cfg.cross_bc_alpha);
        for (int r = 0; r < 3; r++) pi[r] = longint'(mdl_pos[fi * 3 + r]);
        for (int n = 0; n < nops; n++) begin
            for (int c = 0; c < 3; c++) begin
                acc = '0;
                for (int r = 0; r < 3; r++)
                    acc = acc + 64'(pi[r] * longint'(mdl_matrix[n * 9 + r * 3 + c]));
                acc = acc + (64'(longint'(mdl_shift[n * 3 + c])) << 24);
                acc = acc - ((64'(longint'(mdl_pos[se * 3 + c])) << 24)
                             + 64'(ssd_pkg::HALF48));
                dp[c] = longint'({40'd0, acc[47:24]}) - 64'sh800000;
            end
            dk2 = ((dp[0] * dp[0]) >>> 24) * longint'({33'd0, mdl_cfg.a_squared})
                + ((dp[1] * dp[1]) >>> 24) * longint'({33'd0, mdl_cfg.b_squared})
                + ((dp[2] * dp[2]) >>> 24) * longint'({33'd0, mdl_cfg.c_squared})
                + 2 * (((dp[0] * dp[1]) >>> 24) * gxy
                     + ((dp[0] * dp[2]) >>> 24) * gxz
                     + ((dp[1] * dp[2]) >>> 24) * gyz);
            if (dk2 < 0 || dk2 > (longint'(16) <<< 40)) continue;
            dk = longint'((isqrt(64'(dk2)) + 8) >> 4);
            if (n > 0) dk = dk + longint'(ssd_pkg::PENALTY);
            if (dk > longint'(ssd_pkg::MIN_DIST) && (!found || best_d >= dk)) begin
                found = 1;
                best_d = dk;
                best_n = n;
            end
        end
        res = '0;
        if (!found) return 0;
        no_h = !mdl_hyd[fi] && !mdl_hyd[se];
        cut = 0;
        if ((no_h && (mdl_part[fi] == 0 || mdl_part[se] == 0)) || mdl_part[fi] == mdl_part[se])
            cut = (12 * (longint'(mdl_radius[fi]) + longint'(mdl_radius[se])) + 5) / 10;
        res.atom_i        = it.first_index;
        res.atom_j        = it.second_index;
        res.best_symmetry = best_n[5:0];
        res.distance      = best_d[18:0];
        res.cutoff        = cut[19:0];
        res.covalent      = (best_d < cut);
        return 1;
    endfunction

    // apply one accepted item to the predictor state
    task automatic absorb_item(input ssd_pkg::t_in_item it);
        ssd_pkg::t_out_item res;
        int                 fi;
        fi = it.first_index;
        case (it.op)
            ssd_pkg::OP_LOAD_SYM: begin
                if (fi < ssd_pkg::MAX_SYMMETRY && it.axis <= ssd_pkg::AXIS_LAST) begin
                    mdl_matrix[fi * 9 + 0 + it.axis] = it.value_x;
                    mdl_matrix[fi * 9 + 3 + it.axis] = it.value_y;
                    mdl_matrix[fi * 9 + 6 + it.axis] = it.value_z;
                    mdl_shift[fi * 3 + it.axis]      = it.value_shift;
                end
            end
            ssd_pkg::OP_LOAD_ATOM: begin
                mdl_pos[fi * 3 + 0] = it.value_x;
                mdl_pos[fi * 3 + 1] = it.value_y;
                mdl_pos[fi * 3 + 2] = it.value_z;
                mdl_radius[fi]      = it.radius;
                mdl_hyd[fi]         = it.hydrogen;
                mdl_part[fi]        = it.part;
            end
            ssd_pkg::OP_QUERY: begin
                if (nearest_copy(it, res)) expected_pairs.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [31:0] d);
        case (idx)
            ssd_pkg::CFG_GXY:   mdl_cfg.cross_ab_gamma = d;
            ssd_pkg::CFG_GXZ:   mdl_cfg.cross_ac_beta  = d;
            ssd_pkg::CFG_GYZ:   mdl_cfg.cross_bc_alpha = d;
            ssd_pkg::CFG_ASQ:   mdl_cfg.a_squared      = d[30:0];
            ssd_pkg::CFG_BSQ:   mdl_cfg.b_squared      = d[30:0];
            ssd_pkg::CFG_CSQ:   mdl_cfg.c_squared      = d[30:0];
            ssd_pkg::CFG_COUNT: mdl_cfg.symmetry_count = d[6:0];
            default: ;
        endcase
    endtask

    // monitor: items, results and register writes are taken at the rising edge
    always @(posedge i_clk) begin
        ssd_pkg::t_out_item want;
        bit                 moved;
        moved = 0;
        sent = 0;
        if (i_rst_n) begin
            if (start && !busy) begin
                absorb_item(i_item);
                sent = 1;
                moved = 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(i_cfg_index, i_cfg_data);
                moved = 1;
            end
            if (o_valid) begin
                moved = 1;
                if (expected_pairs.size() == 0) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: got %p", o_result);
                end else begin
                    want = expected_pairs.pop_front();
                    if (o_result.atom_i !== want.atom_i || o_result.atom_j !== want.atom_j
                        || o_result.best_symmetry !== want.best_symmetry
                        || o_result.distance !== want.distance
                        || o_result.cutoff !== want.cutoff
                        || o_result.covalent !== want.covalent) begin
                        failed = 1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result differs: expected %p got %p", want, o_result);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("symmetry_shortest_distance: mismatch");
                $finish;
            end
        end
    end

    // driver: one update of start and the item per falling edge
    always @(negedge i_clk) begin
        logic              nxt_start;
        ssd_pkg::t_in_item nxt_item;
        nxt_start = start;
        nxt_item = i_item;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!start || sent) begin
            if (pending_items.size() == 0 || (!no_gaps && $urandom_range(99) < 8)) begin
                nxt_start = 1'b0;
            end else begin
                nxt_start = 1'b1;
                nxt_item = pending_items.pop_front();
            end
        end
        start <= nxt_start;
        i_item <= nxt_item;
    end

    function automatic ssd_pkg::t_in_item noise_item();
        ssd_pkg::t_in_item it;
        logic [191:0]      raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(ssd_pkg::t_in_item)-1:0];
        if ($urandom_range(1)) it.part = 8'($signed($urandom_range(198)) - 99);
        else it.part = 8'($urandom_range(99));
        return it;
    endfunction

    function automatic logic [31:0] matrix_entry();
        case ($urandom_range(9))
            0, 1, 2: return ONE_Q24[31:0];
            3, 4: return -ONE_Q24[31:0];
            5: return $urandom;
            default: return 32'd0;
        endcase
    endfunction

    task automatic queue_sym_column(input int idx, input int ax);
        ssd_pkg::t_in_item it;
        it = noise_item();
        it.op = ssd_pkg::OP_LOAD_SYM;
        it.first_index = 10'(idx);
        it.axis = 2'(ax);
        it.value_x = matrix_entry();
        it.value_y = matrix_entry();
        it.value_z = matrix_entry();
        case ($urandom_range(3))
            0: it.value_shift = 32'd0;
            1: it.value_shift = 32'($urandom_range(3)) << 22;
            2: it.value_shift = $urandom;
            default: it.value_shift = -(32'($urandom_range(4)) << 22);
        endcase
        pending_items.push_back(it);
    endtask

    task automatic queue_atom(input int idx);
        ssd_pkg::t_in_item it;
        it = noise_item();
        it.op = ssd_pkg::OP_LOAD_ATOM;
        it.first_index = 10'(idx);
        if ($urandom_range(9) != 0) begin
            it.value_x = $urandom_range(32'hFFFFFF);
            it.value_y = $urandom_range(32'hFFFFFF);
            it.value_z = $urandom_range(32'hFFFFFF);
            it.radius = 18'($urandom_range(65536, 19660));
        end
        pending_items.push_back(it);
        if (!atom_written[idx]) begin
            atom_written[idx] = 1;
            atom_list.push_back(idx);
        end
    endtask

    task automatic queue_query(input int a, input int b);
        ssd_pkg::t_in_item it;
        it = noise_item();
        it.op = ssd_pkg::OP_QUERY;
        it.first_index = 10'(a);
        it.second_index = 10'(b);
        pending_items.push_back(it);
    endtask

    task automatic queue_random(input int n);
        int                k;
        ssd_pkg::t_in_item it;
        for (int q = 0; q < n; q++) begin
            k = $urandom_range(99);
            if (k < 55) begin
                queue_query(atom_list[$urandom_range(atom_list.size() - 1)],
                            atom_list[$urandom_range(atom_list.size() - 1)]);
            end else if (k < 80) begin
                queue_atom($urandom_range(9) < 7 ? $urandom_range(31) : $urandom_range(1023));
            end else if (k < 95) begin
                queue_sym_column($urandom_range(ssd_pkg::MAX_SYMMETRY - 1), $urandom_range(2));
            end else begin
                // ignored: reserved op, reserved axis or symmetry index out of range
                it = noise_item();
                case ($urandom_range(2))
                    0: it.op = ssd_pkg::OP_RESERVED;
                    1: begin
                        it.op = ssd_pkg::OP_LOAD_SYM;
                        it.axis = ssd_pkg::AXIS_RESERVED;
                    end
                    default: begin
                        it.op = ssd_pkg::OP_LOAD_SYM;
                        it.first_index = 10'($urandom_range(1023, ssd_pkg::MAX_SYMMETRY));
                    end
                endcase
                pending_items.push_back(it);
            end
        end
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !start);
        wait (expected_pairs.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_metric(input logic [31:0] gxy, input logic [31:0] gxz,
                              input logic [31:0] gyz, input logic [31:0] asq,
                              input logic [31:0] bsq, input logic [31:0] csq,
                              input logic [31:0] cnt);
        write_reg(ssd_pkg::CFG_GXY, gxy);
        write_reg(ssd_pkg::CFG_GXZ, gxz);
        write_reg(ssd_pkg::CFG_GYZ, gyz);
        write_reg(ssd_pkg::CFG_ASQ, asq);
        write_reg(ssd_pkg::CFG_BSQ, bsq);
        write_reg(ssd_pkg::CFG_CSQ, csq);
        write_reg(ssd_pkg::CFG_COUNT, cnt);
    endtask

    function automatic logic [31:0] edge_sq(input int lo, input int hi);
        return 32'($urandom_range(hi, lo)) * 32'($urandom_range(hi, lo)) * 32'd65536;
    endfunction

    function automatic logic [31:0] cross_term();
        return 32'($signed($urandom_range(40 * 65536)) - 20 * 65536);
    endfunction

    initial begin
        ssd_pkg::t_in_item it;
        mdl_cfg = '{cross_ab_gamma: 0, cross_ac_beta: 0, cross_bc_alpha: 0,
                    a_squared: 65536, b_squared: 65536, c_squared: 65536,
                    symmetry_count: 1};
        mismatches = 0;
        failed = 0;
        sent = 0;
        no_gaps = 0;
        quiet_cycles = 0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity first, then every operation fully written
        for (int ax = 0; ax < 3; ax++) begin
            it = noise_item();
            it.op = ssd_pkg::OP_LOAD_SYM;
            it.first_index = '0;
            it.axis = 2'(ax);
            it.value_x = (ax == 0) ? ONE_Q24[31:0] : 32'd0;
            it.value_y = (ax == 1) ? ONE_Q24[31:0] : 32'd0;
            it.value_z = (ax == 2) ? ONE_Q24[31:0] : 32'd0;
            it.value_shift = 32'd0;
            pending_items.push_back(it);
        end
        for (int n = 1; n < ssd_pkg::MAX_SYMMETRY; n++)
            for (int ax = 0; ax < 3; ax++) queue_sym_column(n, ax);

        // directed atoms: radius and part extremes, hydrogen, extreme positions
        for (int a = 0; a < 8; a++) queue_atom(a);
        pending_items[$ - 7].radius = 18'd0;
        pending_items[$ - 7].hydrogen = 1'b0;
        pending_items[$ - 7].part = 8'sd0;
        pending_items[$ - 6].radius = 18'h3FFFF;
        pending_items[$ - 6].part = 8'sd0;
        pending_items[$ - 5].hydrogen = 1'b1;
        pending_items[$ - 4].part = 8'sd99;
        pending_items[$ - 4].hydrogen = 1'b0;
        pending_items[$ - 3].part = -8'sd99;
        pending_items[$ - 2].part = 8'sd99;
        pending_items[$ - 2].radius = 18'h3FFFF;
        pending_items[$ - 1].value_x = 32'h8000_0000;
        pending_items[$ - 1].value_y = 32'h7FFF_FFFF;
        pending_items[$].value_x = 32'h7FFF_FFFF;
        pending_items[$].value_z = 32'h8000_0000;
        queue_query(0, 0);      // identity only, zero distance: no result
        queue_query(0, 1);
        queue_query(1, 0);
        queue_query(1, 2);
        queue_query(3, 5);
        queue_query(3, 4);
        queue_query(2, 3);
        queue_query(6, 7);
        queue_query(7, 6);
        queue_query(1, 1);
        queue_random(40);
        drain();

        no_gaps = 1;
        set_metric(0, 0, 0, 32'd64 << 16, 32'd64 << 16, 32'd64 << 16, 4);
        queue_random(250);
        drain();
        no_gaps = 0;

        set_metric(0, cross_term(), 0, edge_sq(4, 9), edge_sq(4, 9), edge_sq(4, 9), 2);
        queue_random(125);
        drain();    // sender holds until all results are in
        queue_random(125);
        drain();

        set_metric(cross_term(), cross_term(), cross_term(), edge_sq(3, 6), edge_sq(3, 6),
                   edge_sq(3, 6), ssd_pkg::MAX_SYMMETRY);
        for (int q = 0; q < 12; q++)
            queue_query(atom_list[$urandom_range(atom_list.size() - 1)],
                        atom_list[$urandom_range(atom_list.size() - 1)]);
        drain();

        set_metric(0, 0, 0, edge_sq(3, 6), edge_sq(3, 6), edge_sq(3, 6), 127);
        queue_random(8);
        drain();

        set_metric(0, 0, 0, 32'd16 << 16, 32'd16 << 16, 32'd16 << 16, 0);
        queue_random(20);
        drain();

        set_metric(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                   32'h7FFF_FFFF, 8);
        queue_random(100);
        drain();

        // metric that is not positive definite
        set_metric(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'd1 << 16, 32'd1 << 16,
                   32'd1 << 16, 3);
        queue_random(150);
        drain();

        for (int p = 0; p < 4; p++) begin
            if (p == 3)
                set_metric($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 5);
            else
                set_metric(cross_term(), cross_term(), cross_term(), edge_sq(3, 9),
                           edge_sq(3, 9), edge_sq(3, 9), $urandom_range(8, 1));
            queue_random(150);
            drain();
        end

        if (!failed && expected_pairs.size() == 0) begin
            $display("symmetry_shortest_distance: match");
        end else begin
            $display("symmetry_shortest_distance: mismatch");
        end
        $finish;
    end

endmodule

### symmetry_shortest_distance.f
rtl/core/ssd_pkg.sv
rtl/core/ssd_front.sv
rtl/core/ssd_back.sv
rtl/core/symmetry_shortest_distance.sv
tb/testbench.sv
